[hw/rtl/bb3_pkg.sv]
// bb3_pkg: shared types and constants for the 3x3 box blur.
// Used by every module of box_blur_3x3_gray; no dependencies.
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 256;

  localparam int FW_W  = 9;
  localparam int FH_W  = 12;
  localparam int PIX_W = 8;
  localparam int COL_W = 8;
  localparam int SUM_W = 12;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 9'd200;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd100;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // divide by nine: (sum * 7282) >> 16 is exact for sum <= 2295
  localparam int               RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int               RECIP_SHIFT = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [FH_W-1:0]  row;
    logic [COL_W-1:0] col;
    logic             done;
  } bb3_item_t;

endpackage

`default_nettype wire

[hw/rtl/bb3_front.sv]
// bb3_front: accepts pixels, tracks position, keeps the line memory and window,
// and pushes the neighborhood sum of each interior pixel. Depends on bb3_pkg.
`default_nettype none

module bb3_front import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [FW_W-1:0]  frame_width,
  input  wire logic [FH_W-1:0]  frame_height,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic             start_of_frame,
  output logic                  push,
  output bb3_item_t             push_item,
  input  wire logic             q_full
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EXW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [CW-1:0]      col_cnt;
  logic [FH_W-1:0]    row_cnt;
  logic [EXW-1:0]     eff_w;
  logic [EXW-1:0]     fw_ext;
  logic [FH_W-1:0]    eff_h;
  logic [CW-1:0]      c_cur;
  logic [FH_W-1:0]    r_cur;
  logic [EXW-1:0]     c_ext;
  logic [EXW-1:0]     c_inc;
  logic [FH_W:0]      r_inc;
  logic               acc;
  logic               emit;
  logic               done;

  logic               s1_valid;
  logic               s1_adv;
  logic [PIX_W-1:0]   s1_px;
  logic               s1_emit;
  logic               s1_done;
  logic [FH_W-1:0]    s1_row;
  logic [COL_W-1:0]   s1_col;
  logic [CW-1:0]      s1_addr;
  logic [2*PIX_W-1:0] lb_rd;
  logic [2*PIX_W-1:0] wr_word;
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   win [6];
  logic [SUM_W-1:0]   sum;
  logic [CW:0]        c_m1;

  always_comb begin
    fw_ext = EXW'(frame_width);
    if (fw_ext < EXW'(3)) begin
      eff_w = EXW'(3);
    end else if (fw_ext > EXW'(MAX_WIDTH)) begin
      eff_w = EXW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (frame_height < 12'd3) ? 12'd3 : frame_height;
  end

  assign in_stall = s1_valid && q_full;
  assign acc      = in_valid && !in_stall;
  assign s1_adv   = s1_valid && !q_full;

  assign c_cur = start_of_frame ? '0 : col_cnt;
  assign r_cur = start_of_frame ? '0 : row_cnt;
  assign c_ext = EXW'(c_cur);
  assign c_inc = c_ext + EXW'(1);
  assign r_inc = {1'b0, r_cur} + 13'd1;
  assign c_m1  = {1'b0, c_cur} - (CW+1)'(1);

  assign emit = (r_cur >= 12'd2) && (c_ext >= EXW'(2)) && (r_cur < eff_h) && (c_ext < eff_w);
  assign done = (r_cur == eff_h - 12'd1) && (c_ext == eff_w - EXW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
        if (c_inc >= eff_w) begin
          col_cnt <= '0;
          row_cnt <= (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[FH_W-1:0];
        end else begin
          col_cnt <= c_inc[CW-1:0];
          row_cnt <= r_cur;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px   <= pixel;
      s1_emit <= emit;
      s1_done <= done;
      s1_row  <= r_cur - 12'd1;
      s1_col  <= COL_W'(c_m1);
      s1_addr <= c_cur;
    end
  end

  // line memory word: {older row, newer row}
  assign wr_word = {lb_rd[PIX_W-1:0], s1_px};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_addr] <= wr_word;
    end
    if (acc) begin
      lb_rd <= (s1_adv && s1_addr == c_cur) ? wr_word : line_mem[c_cur];
    end
  end

  always_comb begin
    sum = SUM_W'(lb_rd[2*PIX_W-1:PIX_W]) + SUM_W'(lb_rd[PIX_W-1:0]) + SUM_W'(s1_px);
    for (int k = 0; k < 6; k++) begin
      sum = sum + SUM_W'(win[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= lb_rd[2*PIX_W-1:PIX_W];
      win[4] <= lb_rd[PIX_W-1:0];
      win[5] <= s1_px;
    end
  end

  assign push           = s1_adv && s1_emit;
  assign push_item.sum  = sum;
  assign push_item.row  = s1_row;
  assign push_item.col  = s1_col;
  assign push_item.done = s1_done;

endmodule

`default_nettype wire

[hw/rtl/bb3_queue.sv]
// bb3_queue: short FIFO of pending window sums between front and back.
// Depends on bb3_pkg for the entry type and depth.
`default_nettype none

module bb3_queue import bb3_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bb3_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output bb3_item_t      head
);

  bb3_item_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bb3_back.sv]
// bb3_back: divides each queued sum by nine and holds the result transaction.
// Depends on bb3_pkg.
`default_nettype none

module bb3_back import bb3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire bb3_item_t   head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [PIX_W-1:0] blurred,
  output logic [FH_W-1:0]  center_row,
  output logic [COL_W-1:0] center_column,
  output logic             frame_done
);

  logic [SUM_W+RECIP_W-1:0] prod;

  assign pop  = head_valid && (!out_valid || !out_stall);
  assign prod = head.sum * RECIP_NINE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blurred       <= prod[RECIP_SHIFT +: PIX_W];
      center_row    <= head.row;
      center_column <= head.col;
      frame_done    <= head.done;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/box_blur_3x3_gray.sv]
// box_blur_3x3_gray: top level of the streaming 3x3 box blur.
// Holds the configuration registers; uses bb3_pkg, bb3_front, bb3_queue, bb3_back.
//
// Streaming 3x3 box filter for 8-bit grayscale pixels in raster order. One pixel
// transaction is taken every clock cycle while in_stall is low; the line memory is read
// and written once per pixel, which sets that rate. Each interior pixel yields one
// result transaction (mean of its 3x3 neighborhood, truncated), registered through the
// front stage, queue and output register, with row, column and a last-of-frame flag;
// border pixels give none. start_of_frame restarts the position counters. The user must
// write width and height only while the block is idle; the block does not enforce it.
`default_nettype none

module box_blur_3x3_gray import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [FH_W-1:0]  cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic             start_of_frame,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      blurred,
  output logic [FH_W-1:0]       center_row,
  output logic [COL_W-1:0]      center_column,
  output logic                  frame_done
);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  bb3_item_t       push_item;
  bb3_item_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bb3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .start_of_frame (start_of_frame),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bb3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blurred       (blurred),
    .center_row    (center_row),
    .center_column (center_column),
    .frame_done    (frame_done)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking testbench for box_blur_3x3_gray, the streaming 3x3 box blur.
// Sends pixel frames under random idle and back-pressure, predicts every blurred pixel
// in a scoreboard class and checks it field by field; needs only bb3_pkg and the RTL.
`default_nettype none

module tb;
  import bb3_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] blurred;
    logic [FH_W-1:0]  row;
    logic [COL_W-1:0] col;
    logic             done;
  } blur_result_t;

  class blur_scoreboard;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] older_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] newer_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    blur_result_t     expected_q [$];
    int               errors;
    int               checked;
    int               frame_ends;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
      checked    = 0;
      frame_ends = 0;
    endfunction

    function void write_reg(logic idx, logic [FH_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[FW_W-1:0];
      end else begin
        height_reg = data;
      end
    endfunction

    // one accepted pixel transaction: update line buffers and window, queue any result
    function void note_pixel(logic [PIX_W-1:0] px, logic sof);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      int unsigned total;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      blur_result_t exp_r;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = (height_reg < 3) ? 3 : height_reg;
      if (sof) begin
        col_pos = 0;
        row_pos = 0;
      end
      idx = (col_pos < MAX_WIDTH_DEF) ? col_pos : MAX_WIDTH_DEF - 1;
      top = older_line[idx];
      mid = newer_line[idx];
      older_line[idx] = mid;
      newer_line[idx] = px;
      total = top + mid + px;
      foreach (win[k]) total += win[k];
      if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
        exp_r.blurred = PIX_W'(total / 9);
        exp_r.row     = FH_W'(row_pos - 1);
        exp_r.col     = COL_W'(col_pos - 1);
        exp_r.done    = (row_pos == h - 1) && (col_pos == w - 1);
        expected_q.push_back(exp_r);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_result(blur_result_t got);
      blur_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: blurred %0d row %0d column %0d",
               got.blurred, got.row, got.col);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.done) frame_ends++;
      if (got.blurred !== exp_r.blurred) begin
        $error("blurred: expected %0d, got %0d", exp_r.blurred, got.blurred);
        errors++;
      end
      if (got.row !== exp_r.row) begin
        $error("center_row: expected %0d, got %0d", exp_r.row, got.row);
        errors++;
      end
      if (got.col !== exp_r.col) begin
        $error("center_column: expected %0d, got %0d", exp_r.col, got.col);
        errors++;
      end
      if (got.done !== exp_r.done) begin
        $error("frame_done: expected %0d, got %0d", exp_r.done, got.done);
        errors++;
      end
    endfunction
  endclass

  // phase geometries: width, height, pixel count, per-mille chance of cutting a frame
  localparam int NUM_PHASES = 5;
  localparam int DIRECTED_PIXELS = 29;
  localparam int PH_WIDTH  [NUM_PHASES] = '{5, 2, 30, 9, 14};
  localparam int PH_HEIGHT [NUM_PHASES] = '{4, 4095, 3, 2, 5};
  localparam int PH_COUNT  [NUM_PHASES] = '{80, 40, 150, 90, 160};
  localparam int PH_CUT_PM [NUM_PHASES] = '{15, 5, 4, 0, 10};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_FRAME_WIDTH;
  logic [FH_W-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] pixel = '0;
  logic             start_of_frame = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] blurred;
  logic [FH_W-1:0]  center_row;
  logic [COL_W-1:0] center_column;
  logic             frame_done;

  int               src_idle_pct = 0;
  int               sink_idle_pct = 0;
  int               pixels_sent = 0;
  int               total_pixels = DIRECTED_PIXELS;
  blur_scoreboard   sb;
  blur_result_t     seen_result;

  box_blur_3x3_gray u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .start_of_frame (start_of_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .blurred        (blurred),
    .center_row     (center_row),
    .center_column  (center_column),
    .frame_done     (frame_done)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
  end

  // sample between edges so both sides have settled
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result.blurred = blurred;
      seen_result.row     = center_row;
      seen_result.col     = center_column;
      seen_result.done    = frame_done;
      sb.check_result(seen_result);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof);
    logic taken;
    case (pixels_sent * 3 / total_pixels)
      0: begin
        src_idle_pct  = 11;
        sink_idle_pct = 53;
      end
      1: begin
        src_idle_pct  = 53;
        sink_idle_pct = 11;
      end
      default: begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel          <= px;
    start_of_frame <= sof;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_pixel(px, sof);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [FH_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_geometry(input logic [FH_W-1:0] w, input logic [FH_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // wait for every queued result, then let border pixels still in flight finish
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected result transactions never arrived", sb.expected_q.size());
      sb.errors++;
      sb.expected_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [PIX_W-1:0] px;
    logic             sof;
    int               roll;
    logic [PIX_W-1:0] bit_walk [9];
    bit_walk = '{8'h01, 8'h02, 8'h04, 8'h08, 8'hFE, 8'h10, 8'h20, 8'h40, 8'h80};
    sb = new();
    for (int p = 0; p < NUM_PHASES; p++) total_pixels += PH_COUNT[p];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // width register keeps 9 bits: 0x201 -> 1, taken as 3; height 0 taken as 3
    set_geometry(12'h201, 12'h000);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'h00, 1'b0);
    send_pixel(8'h55, 1'b1);
    send_pixel(8'hAA, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(bit_walk[i], i == 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_geometry(FH_W'(PH_WIDTH[p]), FH_W'(PH_HEIGHT[p]));
      for (int i = 0; i < PH_COUNT[p]; i++) begin
        if (i == 0) begin
          sof = 1'b1;
        end else if (sb.col_pos == 0 && sb.row_pos == 0) begin
          sof = ($urandom_range(0, 9) < 7);
        end else begin
          sof = ($urandom_range(0, 999) < PH_CUT_PM[p]);
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          px = 8'hFF;
        end else if (roll < 16) begin
          px = 8'h00;
        end else begin
          px = PIX_W'($urandom_range(0, 255));
        end
        send_pixel(px, sof);
      end
      drain();
    end

    $display("tb: %0d pixel transactions over %0d frame geometries; %0d blurred pixels checked",
             pixels_sent, NUM_PHASES + 1, sb.checked);
    $display("tb: %0d of them flagged the last interior pixel of a frame", sb.frame_ends);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
